// File: sv/assert_macros.svh
// Assertion macros used by the RGB to HSV RTL.
// Depends on nothing; the user supplies signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_SAME_CYCLE(label, ante, cons, msg)
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg)
`endif
`endif

// File: sv/rgbhsv_pkg.sv
// Types, constants and the division step function of the RGB to HSV converter.
// Used by rgbhsv_divider and rgb_to_hsv_converter_unit; depends on nothing.
package rgbhsv_pkg;

   localparam int CHAN_W             = 8;
   localparam int NUM_W              = 24;
   localparam int QUOT_W             = 16;
   localparam int DIV_STAGES         = 4;
   localparam int DIV_BITS_PER_STAGE = QUOT_W / DIV_STAGES;

   localparam logic [15:0] HUE_TURN   = 16'd23040;
   localparam logic [15:0] HUE_GREEN  = 16'd7680;
   localparam logic [15:0] HUE_BLUE   = 16'd15360;
   localparam logic [15:0] HUE_RED    = 16'd0;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } rgbhsv_req_type;

   typedef struct packed {
      logic [14:0] hue_out;
      logic [15:0] saturation_out;
      logic [7:0]  value_out;
   } rgbhsv_rsp_type;

   // Per-pixel information that rides alongside the two divisions.
   typedef struct packed {
      logic [7:0] value;
      logic [1:0] sector;
      logic       neg;
      logic       grey;
      logic       black;
   } hue_side_type;

   typedef struct packed {
      logic [NUM_W-1:0]  sat_num;
      logic [CHAN_W-1:0] sat_den;
      logic [NUM_W-1:0]  hue_num;
      logic [CHAN_W-1:0] hue_den;
      hue_side_type      side;
   } div_in_type;

   typedef struct packed {
      logic [QUOT_W-1:0] sat_quot;
      logic [QUOT_W-1:0] hue_quot;
      hue_side_type      side;
   } div_out_type;

   // The working word holds the partial remainder in its top byte and the
   // unused numerator bits below; quotient bits shift in at the bottom.
   // The numerator must be below den * 2**QUOT_W so the remainder fits.
   function automatic logic [NUM_W-1:0] div_digit(input logic [NUM_W-1:0] w,
                                                  input logic [CHAN_W-1:0] den);
      logic [NUM_W-1:0] acc;
      logic [CHAN_W:0]  t;
      acc = w;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         t = {acc[NUM_W-1:QUOT_W], acc[QUOT_W-1]};
         if (t >= {1'b0, den}) begin
            acc = {CHAN_W'(t - {1'b0, den}), acc[QUOT_W-2:0], 1'b1};
         end else begin
            acc = {t[CHAN_W-1:0], acc[QUOT_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// File: sv/rgb_to_hsv_converter_unit.sv
// Channel   | Direction | Handshake              | Payload
// req_      | in        | req_valid / req_stall  | rgbhsv_req_type (red, green, blue)
// rsp_      | out       | rsp_valid / rsp_stall  | rgbhsv_rsp_type (hue, saturation, value)
//
// One pixel per cycle while rsp_ is not stalled, through six register stages. The edge
// that accepts a request loads max, min and the numerators, the divider stages of four
// quotient bits each follow, and the output register then takes the hue offset result.
// Synchronous reset clears only the valid bits. Each stage loads whenever it
// is empty or its content moves on, so a stall on rsp_ fills the bubbles first.
// Top level of the RGB to HSV converter; depends on rgbhsv_pkg, rgbhsv_divider
// and assert_macros.svh.
`include "assert_macros.svh"

module rgb_to_hsv_converter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rgbhsv_pkg::rgbhsv_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rgbhsv_pkg::rgbhsv_rsp_type rsp_data
);
   import rgbhsv_pkg::*;

   // Front stage: extremes, sector and the two numerators.
   logic [7:0]      mx;
   logic [7:0]      mn;
   logic [7:0]      delta;
   logic [7:0]      pos_a;
   logic [7:0]      pos_b;
   logic [7:0]      abs_diff;
   div_in_type      front_in;
   logic            front_valid_ff;
   div_in_type      front_ff;
   logic            front_enable;

   logic            div_in_stall;
   logic            div_out_valid;
   logic            div_out_stall;
   div_out_type     div_out;

   logic            rsp_valid_ff;
   rgbhsv_rsp_type  rsp_ff;
   rgbhsv_rsp_type  rsp_in;
   logic            rsp_enable;
   logic [15:0]     offset;
   logic [15:0]     hue_q;
   logic [15:0]     hue_sum;

   always_comb begin
      mx = (req_data.red_in > req_data.green_in) ? req_data.red_in : req_data.green_in;
      mx = (mx > req_data.blue_in) ? mx : req_data.blue_in;
      mn = (req_data.red_in < req_data.green_in) ? req_data.red_in : req_data.green_in;
      mn = (mn < req_data.blue_in) ? mn : req_data.blue_in;
      delta = mx - mn;

      // The signed difference is pos_a - pos_b; ties for the maximum go to red,
      // then green.
      priority if (req_data.red_in == mx) begin
         front_in.side.sector = SECTOR_RED;
         pos_a = req_data.green_in;
         pos_b = req_data.blue_in;
      end else if (req_data.green_in == mx) begin
         front_in.side.sector = SECTOR_GREEN;
         pos_a = req_data.blue_in;
         pos_b = req_data.red_in;
      end else begin
         front_in.side.sector = SECTOR_BLUE;
         pos_a = req_data.red_in;
         pos_b = req_data.green_in;
      end
      front_in.side.neg = pos_a < pos_b;
      abs_diff = front_in.side.neg ? (pos_b - pos_a) : (pos_a - pos_b);

      front_in.side.value = mx;
      front_in.side.grey  = delta == 8'd0;
      front_in.side.black = mx == 8'd0;

      // 65535 * delta and 3840 * |diff| as shift-and-subtract.
      front_in.sat_num = {delta, 16'd0} - {16'd0, delta};
      front_in.sat_den = mx;
      front_in.hue_num = {4'd0, abs_diff, 12'd0} - {8'd0, abs_diff, 8'd0};
      front_in.hue_den = delta;
   end

   assign front_enable = !front_valid_ff || !div_in_stall;
   assign req_stall    = !front_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_enable) begin
         front_valid_ff <= req_valid;
      end
      if (front_enable) begin
         front_ff <= front_in;
      end
   end

   rgbhsv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid_ff),
      .in_stall  (div_in_stall),
      .in_data   (front_ff),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall),
      .out_data  (div_out)
   );

   // Hue is offset plus or minus the quotient; only the red sector can wrap
   // below zero, and then a full turn is added.
   always_comb begin
      unique case (div_out.side.sector)
         SECTOR_RED:   offset = HUE_RED;
         SECTOR_GREEN: offset = HUE_GREEN;
         SECTOR_BLUE:  offset = HUE_BLUE;
         default:      offset = HUE_RED;
      endcase
      hue_q = div_out.hue_quot;
      if (!div_out.side.neg) begin
         hue_sum = offset + hue_q;
      end else if (hue_q > offset) begin
         hue_sum = HUE_TURN + offset - hue_q;
      end else begin
         hue_sum = offset - hue_q;
      end
      rsp_in.hue_out        = div_out.side.grey ? 15'd0 : hue_sum[14:0];
      rsp_in.saturation_out = div_out.side.black ? 16'd0 : div_out.sat_quot;
      rsp_in.value_out      = div_out.side.value;
   end

   assign rsp_enable    = !rsp_valid_ff || !rsp_stall;
   assign div_out_stall = !rsp_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_enable) begin
         rsp_valid_ff <= div_out_valid;
      end
      if (rsp_enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_SAME_CYCLE(a_hue_range, rsp_valid_ff, rsp_ff.hue_out < HUE_TURN[14:0], "hue out of range")
   `ASSERT_SAME_CYCLE(a_black_zero, rsp_valid_ff && rsp_ff.value_out == 8'd0, rsp_ff.saturation_out == 16'd0 && rsp_ff.hue_out == 15'd0, "black pixel has nonzero hue or saturation")
   `ASSERT_SAME_CYCLE(a_stall_when_full, req_stall, front_valid_ff && div_in_stall, "request stalled with room in the front stage")
   `ASSERT_NEXT_CYCLE(a_accept_loads, req_valid && !req_stall, front_valid_ff, "accepted request missing from front stage")

endmodule

// File: sv/rgbhsv_divider.sv
// Pipelined restoring divider with two lanes (saturation and hue quotients).
// Depends on rgbhsv_pkg for the lane types and the per-stage step function.
module rgbhsv_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  rgbhsv_pkg::div_in_type  in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output rgbhsv_pkg::div_out_type out_data
);
   import rgbhsv_pkg::*;

   logic                    valid_ff [DIV_STAGES];
   logic [NUM_W-1:0]        sat_w_ff [DIV_STAGES];
   logic [NUM_W-1:0]        hue_w_ff [DIV_STAGES];
   logic [CHAN_W-1:0]       sat_d_ff [DIV_STAGES];
   logic [CHAN_W-1:0]       hue_d_ff [DIV_STAGES];
   hue_side_type            side_ff  [DIV_STAGES];

   logic                    valid_src [DIV_STAGES];
   logic [NUM_W-1:0]        sat_w_src [DIV_STAGES];
   logic [NUM_W-1:0]        hue_w_src [DIV_STAGES];
   logic [CHAN_W-1:0]       sat_d_src [DIV_STAGES];
   logic [CHAN_W-1:0]       hue_d_src [DIV_STAGES];
   hue_side_type            side_src  [DIV_STAGES];
   logic                    enable    [DIV_STAGES];

   always_comb begin
      valid_src[0] = in_valid;
      sat_w_src[0] = in_data.sat_num;
      hue_w_src[0] = in_data.hue_num;
      sat_d_src[0] = in_data.sat_den;
      hue_d_src[0] = in_data.hue_den;
      side_src[0]  = in_data.side;
      for (int s = 1; s < DIV_STAGES; s++) begin
         valid_src[s] = valid_ff[s-1];
         sat_w_src[s] = sat_w_ff[s-1];
         hue_w_src[s] = hue_w_ff[s-1];
         sat_d_src[s] = sat_d_ff[s-1];
         hue_d_src[s] = hue_d_ff[s-1];
         side_src[s]  = side_ff[s-1];
      end
   end

   // A stage may load when it is empty or its content moves on this cycle,
   // so bubbles close up behind a stalled output.
   always_comb begin
      enable[DIV_STAGES-1] = !valid_ff[DIV_STAGES-1] || !out_stall;
      for (int s = DIV_STAGES - 2; s >= 0; s--) begin
         enable[s] = !valid_ff[s] || enable[s+1];
      end
   end

   assign in_stall = !enable[0];

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable[s]) begin
            valid_ff[s] <= valid_src[s];
         end
         if (enable[s]) begin
            sat_w_ff[s] <= div_digit(sat_w_src[s], sat_d_src[s]);
            hue_w_ff[s] <= div_digit(hue_w_src[s], hue_d_src[s]);
            sat_d_ff[s] <= sat_d_src[s];
            hue_d_ff[s] <= hue_d_src[s];
            side_ff[s]  <= side_src[s];
         end
      end
   end

   assign out_valid         = valid_ff[DIV_STAGES-1];
   assign out_data.sat_quot = sat_w_ff[DIV_STAGES-1][QUOT_W-1:0];
   assign out_data.hue_quot = hue_w_ff[DIV_STAGES-1][QUOT_W-1:0];
   assign out_data.side     = side_ff[DIV_STAGES-1];

endmodule
